// ===== design/lncs_pkg.sv =====
// Package for the LCD nibble command sequencer: microcode word types and program ROM.
package lncs_pkg;

	// Micro program counter width; the program has 17 steps
	localparam int unsigned UPC_W = 5;

	// Datapath actions that one micro step may perform
	typedef enum logic [2:0] {
		A_NONE,
		A_ENQ,      // push request, arm tick, acknowledge
		A_IDLE,     // idle tick: disarm or go to prepare
		A_PREP,     // prepare tick: dequeue or fall back to idle
		A_BUSY,     // check-busy tick: go to prepare
		A_EMIT,     // emit one expander byte
		A_SENDEND   // clear held command, go to check-busy
	} act_t;

	// Branch conditions tested by a micro step
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_TICK,
		C_DISARMED,
		C_ST_IDLE,
		C_ST_PREP,
		C_ST_SEND,
		C_NOT_HELD
	} cond_t;

	// One control word: when cond holds, finish if fin is set, else jump to target; otherwise step on
	typedef struct packed {
		act_t             act;
		cond_t            cond;
		logic [UPC_W-1:0] target;
		logic             fin;
		logic             nib_lo;
		logic             en;
		logic             last;
	} uword_t;

	// Program addresses
	localparam logic [UPC_W-1:0] U_DISPATCH = 5'd0;
	localparam logic [UPC_W-1:0] U_ENQ      = 5'd1;
	localparam logic [UPC_W-1:0] U_TICK     = 5'd2;
	localparam logic [UPC_W-1:0] U_IDLE     = 5'd8;
	localparam logic [UPC_W-1:0] U_PREP     = 5'd10;
	localparam logic [UPC_W-1:0] U_SEND     = 5'd11;
	localparam logic [UPC_W-1:0] U_SENDEND  = 5'd16;

	// Program ROM
	function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
		uword_t w;
		w = '{act: A_NONE, cond: C_ALWAYS, target: U_DISPATCH, fin: 1'b1,
			nib_lo: 1'b0, en: 1'b0, last: 1'b0};
		case (addr)
			U_DISPATCH: begin
				w.cond = C_TICK; w.target = U_TICK; w.fin = 1'b0;
			end
			U_ENQ: begin
				w.act = A_ENQ; w.last = 1'b1;
			end
			U_TICK: begin
				w.cond = C_DISARMED;
			end
			5'd3: begin
				w.cond = C_ST_IDLE; w.target = U_IDLE; w.fin = 1'b0;
			end
			5'd4: begin
				w.cond = C_ST_PREP; w.target = U_PREP; w.fin = 1'b0;
			end
			5'd5: begin
				w.cond = C_ST_SEND; w.target = U_SEND; w.fin = 1'b0;
			end
			5'd6: begin
				w.act = A_BUSY;
			end
			U_IDLE: begin
				w.act = A_IDLE;
			end
			U_PREP: begin
				w.act = A_PREP;
			end
			U_SEND: begin
				w.cond = C_NOT_HELD; w.target = U_SENDEND; w.fin = 1'b0;
			end
			5'd12: begin
				w.act = A_EMIT; w.cond = C_NEVER; w.fin = 1'b0; w.en = 1'b1;
			end
			5'd13: begin
				w.act = A_EMIT; w.cond = C_NEVER; w.fin = 1'b0;
			end
			5'd14: begin
				w.act = A_EMIT; w.cond = C_NEVER; w.fin = 1'b0;
				w.nib_lo = 1'b1; w.en = 1'b1;
			end
			5'd15: begin
				w.act = A_EMIT; w.cond = C_NEVER; w.fin = 1'b0;
				w.nib_lo = 1'b1; w.last = 1'b1;
			end
			U_SENDEND: begin
				w.act = A_SENDEND;
			end
			default: begin
				w.act = A_NONE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== design/lcd_nibble_command_sequencer.sv =====
// LCD nibble command sequencer: microcoded control over a command FIFO and byte formatter.
// Each request is taken when start is high and busy is low, and then runs a short
// microprogram, one step per clock, with busy held high until the program ends.
// Results come out one per cycle, each marked by strobe for exactly one cycle, with
// no way for the receiver to hold them off: an enqueue gives one acknowledge, a send
// tick four expander bytes on consecutive cycles. A full FIFO drops the enqueue
// and flags it on the acknowledge.
// The backlight register is written through cfg_valid/cfg_data and is always ready;
// write it only while the block is idle.
module lcd_nibble_command_sequencer #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       start,
	output logic       busy,
	input  logic       operation,
	input  logic [1:0] register_select,
	input  logic [7:0] command_byte,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	// result channel
	output logic       strobe,
	output logic       result_kind,
	output logic [7:0] expander_byte,
	output logic       last_of_burst,
	output logic       enqueue_dropped
);
	import lncs_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE       = 2'd0,
		ST_CHECK_BUSY = 2'd1,
		ST_SEND       = 2'd2,
		ST_PREPARE    = 2'd3
	} seq_state_t;

	// control
	logic             running_q;
	logic [UPC_W-1:0] upc_q;
	// latched request
	logic             op_q;
	logic [1:0]       rs_q;
	logic [7:0]       cmd_q;
	// sequencer datapath state
	seq_state_t       seq_q;
	logic             armed_q;
	logic             backlight_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [9:0]       held_q;
	logic             held_valid_q;
	logic [9:0]       queue_mem [QUEUE_DEPTH];
	// result registers
	logic             strobe_q;
	logic             kind_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             dropped_q;

	uword_t     uw;
	logic       cond_hit;
	logic       accept;
	logic       q_empty;
	logic       q_full;
	logic       do_enq;
	logic       do_deq;
	logic [3:0] nibble;

	assign accept    = start && !running_q;
	assign busy      = running_q;
	assign cfg_ready = 1'b1;
	assign q_empty   = (count_q == '0);
	assign q_full    = (count_q == CNT_FULL);

	// current control word and its branch condition
	assign uw = ucode_rom(upc_q);
	always_comb begin
		case (uw.cond)
			C_NEVER:    cond_hit = 1'b0;
			C_ALWAYS:   cond_hit = 1'b1;
			C_TICK:     cond_hit = op_q;
			C_DISARMED: cond_hit = !armed_q;
			C_ST_IDLE:  cond_hit = (seq_q == ST_IDLE);
			C_ST_PREP:  cond_hit = (seq_q == ST_PREPARE);
			C_ST_SEND:  cond_hit = (seq_q == ST_SEND);
			C_NOT_HELD: cond_hit = !held_valid_q;
			default:    cond_hit = 1'b0;
		endcase
	end

	assign do_enq = running_q && (uw.act == A_ENQ) && !q_full;
	assign do_deq = running_q && (uw.act == A_PREP) && !q_empty;
	assign nibble = uw.nib_lo ? held_q[3:0] : held_q[7:4];

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			upc_q     <= U_DISPATCH;
		end else if (accept) begin
			running_q <= 1'b1;
			upc_q     <= U_DISPATCH;
		end else if (running_q) begin
			if (cond_hit && uw.fin) begin
				running_q <= 1'b0;
			end else if (cond_hit) begin
				upc_q <= uw.target;
			end else begin
				upc_q <= upc_q + 1'b1;
			end
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			rs_q  <= register_select;
			cmd_q <= command_byte;
		end
	end

	// backlight register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			backlight_q <= cfg_data;
		end
	end

	// command FIFO storage and held command
	always_ff @(posedge clk) begin
		if (do_enq) begin
			queue_mem[tail_q] <= {rs_q, cmd_q};
		end
		if (do_deq) begin
			held_q <= queue_mem[head_q];
		end
	end

	// sequencer state, tick arming and FIFO pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= ST_IDLE;
			armed_q      <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			held_valid_q <= 1'b0;
		end else if (running_q) begin
			case (uw.act)
				A_ENQ: begin
					armed_q <= 1'b1;
					if (!q_full) begin
						tail_q  <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
						count_q <= count_q + 1'b1;
					end
				end
				A_IDLE: begin
					if (q_empty) begin
						armed_q <= 1'b0;
					end else begin
						seq_q <= ST_PREPARE;
					end
				end
				A_PREP: begin
					if (q_empty) begin
						held_valid_q <= 1'b0;
						seq_q        <= ST_IDLE;
						armed_q      <= 1'b0;
					end else begin
						head_q       <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
						count_q      <= count_q - 1'b1;
						held_valid_q <= 1'b1;
						seq_q        <= ST_SEND;
					end
				end
				A_BUSY: begin
					seq_q <= ST_PREPARE;
				end
				A_SENDEND: begin
					held_valid_q <= 1'b0;
					seq_q        <= ST_CHECK_BUSY;
				end
				default: begin
					seq_q <= seq_q;
				end
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= running_q && ((uw.act == A_ENQ) || (uw.act == A_EMIT));
		end
	end

	// result payload: acknowledge or formatted expander byte
	always_ff @(posedge clk) begin
		if (running_q && (uw.act == A_ENQ)) begin
			kind_q    <= 1'b0;
			byte_q    <= '0;
			last_q    <= 1'b1;
			dropped_q <= q_full;
		end else if (running_q && (uw.act == A_EMIT)) begin
			kind_q    <= 1'b1;
			byte_q    <= {nibble, backlight_q, uw.en, held_q[9:8]};
			last_q    <= uw.last;
			dropped_q <= 1'b0;
		end
	end

	assign strobe          = strobe_q;
	assign result_kind     = kind_q;
	assign expander_byte   = byte_q;
	assign last_of_burst   = last_q;
	assign enqueue_dropped = dropped_q;

endmodule

// ===== dv/lcd_nibble_command_sequencer_tb.sv =====
// Self-checking testbench for the LCD nibble command sequencer: queued driver, predictor, monitor.
`timescale 1ns / 100ps

module lcd_nibble_command_sequencer_tb;

	localparam int unsigned FIFO_DEPTH     = 16;
	localparam int          SETTLE_CYCLES  = 16;   // longest program is 11 steps
	localparam int          DRAIN_CYCLES   = 24;
	localparam int          WATCHDOG_LIMIT = 500;

	// Request and result codes
	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_TICK    = 1'b1
	} op_code_t;

	typedef enum logic {
		RK_ACK      = 1'b0,
		RK_EXPANDER = 1'b1
	} result_kind_t;

	// Sequencer states as numbered by the block
	typedef enum logic [1:0] {
		SQ_IDLE       = 2'd0,
		SQ_CHECK_BUSY = 2'd1,
		SQ_SEND       = 2'd2,
		SQ_PREPARE    = 2'd3
	} seq_state_t;

	localparam logic [7:0] NIB_HI_MASK = 8'hF0;
	localparam logic [3:0] NIB_LO_MASK = 4'hF;
	localparam logic [7:0] ENABLE_BIT  = 8'h04;

	typedef struct {
		bit         is_cfg;
		op_code_t   op;
		logic [1:0] rs;
		logic [7:0] cmd;
		logic       backlight;
	} lcd_request_t;

	typedef struct {
		result_kind_t kind;
		logic [7:0]   exp_byte;
		logic         last;
		logic         dropped;
	} lcd_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic       operation = 1'b0;
	logic [1:0] register_select = 2'd0;
	logic [7:0] command_byte = 8'd0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       strobe;
	logic       result_kind;
	logic [7:0] expander_byte;
	logic       last_of_burst;
	logic       enqueue_dropped;

	lcd_request_t cmd_backlog[$];
	lcd_result_t  results_due[$];
	bit           due_empty = 1'b1;
	int           err_count = 0;
	int           idle_cycles = 0;
	int           gap_left = 0;
	int           gapless_left = 0;
	int           settle_cnt = 0;

	// Predictor state
	logic       bl_model;
	seq_state_t seq_model;
	logic       armed_model;
	logic [9:0] fifo_model[$];
	logic [9:0] held_model;
	logic       held_valid_model;

	lcd_nibble_command_sequencer #(
		.QUEUE_DEPTH(FIFO_DEPTH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.register_select(register_select),
		.command_byte   (command_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.strobe         (strobe),
		.result_kind    (result_kind),
		.expander_byte  (expander_byte),
		.last_of_burst  (last_of_burst),
		.enqueue_dropped(enqueue_dropped)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Queue the byte pair of one nibble: enable high, then low
	task automatic push_nibble(input logic [7:0] nib, input logic [1:0] rs, input logic last);
		logic [7:0] b;
		b = nib | ({7'd0, bl_model} << 3) | {6'd0, rs};
		results_due.push_back('{RK_EXPANDER, b | ENABLE_BIT, 1'b0, 1'b0});
		results_due.push_back('{RK_EXPANDER, b, last, 1'b0});
	endtask

	// Advance the sequencer by one accepted request and queue what it emits
	task automatic step_sequencer(input op_code_t op, input logic [1:0] rs, input logic [7:0] cmd);
		bit full;
		if (op == OP_ENQUEUE) begin
			full = (fifo_model.size() >= FIFO_DEPTH);
			if (!full)
				fifo_model.push_back({rs, cmd});
			armed_model = 1'b1;
			results_due.push_back('{RK_ACK, 8'd0, 1'b1, full});
		end else if (armed_model) begin
			case (seq_model)
				SQ_IDLE: begin
					if (fifo_model.size() == 0)
						armed_model = 1'b0;
					else
						seq_model = SQ_PREPARE;
				end
				SQ_PREPARE: begin
					if (fifo_model.size() == 0) begin
						held_valid_model = 1'b0;
						seq_model = SQ_IDLE;
						armed_model = 1'b0;
					end else begin
						held_model = fifo_model.pop_front();
						held_valid_model = 1'b1;
						seq_model = SQ_SEND;
					end
				end
				SQ_SEND: begin
					if (held_valid_model) begin
						push_nibble(held_model[7:0] & NIB_HI_MASK, held_model[9:8], 1'b0);
						push_nibble({held_model[3:0] & NIB_LO_MASK, 4'd0}, held_model[9:8], 1'b1);
					end
					held_valid_model = 1'b0;
					seq_model = SQ_CHECK_BUSY;
				end
				default: begin
					seq_model = SQ_PREPARE;
				end
			endcase
		end
	endtask

	task automatic push_cmd(input op_code_t op, input logic [1:0] rs, input logic [7:0] cmd);
		cmd_backlog.push_back('{1'b0, op, rs, cmd, 1'b0});
	endtask

	task automatic push_cfg(input logic value);
		cmd_backlog.push_back('{1'b1, OP_TICK, 2'd0, 8'd0, value});
	endtask

	// Mostly whole bursts (enqueue then enough ticks to drain), some noise between
	task automatic random_phase(input int n_items);
		int done;
		int k;
		int ticks;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				k = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
				ticks = 3 * k + 2 + $urandom_range(0, 2);
				repeat (k)
					push_cmd(OP_ENQUEUE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				repeat (ticks)
					push_cmd(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				done += k + ticks;
			end else begin
				k = $urandom_range(1, 6);
				repeat (k)
					push_cmd(op_code_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)));
				done += k;
			end
		end
	endtask

	// Request driver: presents the backlog head, with a random gap, possibly none, after each accepted request
	always @(posedge clk or negedge arst_n) begin : driver
		logic start_nxt;
		logic cfg_nxt;
		int   r;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			gap_left = 0;
			settle_cnt = 0;
		end else begin
			start_nxt = start;
			cfg_nxt = cfg_valid;
			if ((start && !busy) || (cfg_valid && cfg_ready)) begin
				void'(cmd_backlog.pop_front());
				start_nxt = 1'b0;
				cfg_nxt = 1'b0;
				if (gapless_left > 0) begin
					gapless_left--;
					gap_left = 0;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 4)
						gapless_left = $urandom_range(10, 30);
					if (r < 50)
						gap_left = 0;
					else if (r < 90)
						gap_left = $urandom_range(1, 3);
					else
						gap_left = $urandom_range(6, 30);
				end
			end
			if (!start_nxt && !cfg_nxt && cmd_backlog.size() != 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_backlog[0].is_cfg) begin
					// register write only once the block has gone quiet
					if (due_empty && !busy) begin
						if (settle_cnt >= SETTLE_CYCLES) begin
							cfg_nxt = 1'b1;
							cfg_data <= cmd_backlog[0].backlight;
							settle_cnt = 0;
						end else begin
							settle_cnt++;
						end
					end else begin
						settle_cnt = 0;
					end
				end else begin
					start_nxt = 1'b1;
					operation <= cmd_backlog[0].op;
					register_select <= cmd_backlog[0].rs;
					command_byte <= cmd_backlog[0].cmd;
				end
			end
			start <= start_nxt;
			cfg_valid <= cfg_nxt;
		end
	end

	// Monitor: check results first, then predict from requests taken at this edge
	always @(posedge clk) begin : monitor
		lcd_result_t want;
		bit          activity;
		if (arst_n) begin
			activity = 1'b0;
			if (strobe) begin
				activity = 1'b1;
				if (results_due.size() == 0) begin
					$error("unexpected result: kind %0d byte 0x%02h last %0d dropped %0d",
						result_kind, expander_byte, last_of_burst, enqueue_dropped);
					err_count++;
				end else begin
					want = results_due.pop_front();
					if (result_kind !== want.kind) begin
						$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
						err_count++;
					end
					if (expander_byte !== want.exp_byte) begin
						$error("expander_byte: expected 0x%02h, got 0x%02h",
							want.exp_byte, expander_byte);
						err_count++;
					end
					if (last_of_burst !== want.last) begin
						$error("last_of_burst: expected %0d, got %0d", want.last, last_of_burst);
						err_count++;
					end
					if (enqueue_dropped !== want.dropped) begin
						$error("enqueue_dropped: expected %0d, got %0d",
							want.dropped, enqueue_dropped);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				activity = 1'b1;
				step_sequencer(op_code_t'(operation), register_select, command_byte);
			end
			if (cfg_valid && cfg_ready) begin
				activity = 1'b1;
				bl_model = cfg_data;
			end
			due_empty <= (results_due.size() == 0);
			idle_cycles <= activity ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog: too long with no request or result moving
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("lcd_nibble_command_sequencer_tb: done, errors");
		$finish;
	end

	initial begin
		bl_model = 1'b1;
		seq_model = SQ_IDLE;
		armed_model = 1'b0;
		held_model = 10'd0;
		held_valid_model = 1'b0;

		// tick before anything is queued is ignored
		push_cmd(OP_TICK, 2'd0, 8'd0);
		// field extremes and both RS/RW bits
		push_cmd(OP_ENQUEUE, 2'd0, 8'h00);
		push_cmd(OP_ENQUEUE, 2'd3, 8'hFF);
		push_cmd(OP_ENQUEUE, 2'd1, 8'hA5);
		push_cmd(OP_ENQUEUE, 2'd2, 8'h5A);
		// drain: idle to prepare, three ticks per command, empty prepare that disarms, one ignored tick
		repeat (15)
			push_cmd(OP_TICK, 2'd3, 8'hFF);
		// disarmed again, so ignored
		push_cmd(OP_TICK, 2'd1, 8'h0F);

		push_cfg(1'b0);
		random_phase(100);
		push_cfg(1'b1);
		random_phase(100);
		push_cfg(1'($urandom_range(0, 1)));
		random_phase(100);
		push_cfg(1'b0);
		random_phase(90);

		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (err_count == 0)
			$display("lcd_nibble_command_sequencer_tb: done, clean");
		else
			$display("lcd_nibble_command_sequencer_tb: done, errors");
		$finish;
	end

endmodule
